// File: rtl/ctr_pkg.sv
// ----------------------------------------------------------------------------
// ctr_pkg: shared types and constants of the closest target ranker
// Command and action codes, register indexes, the configuration struct and
// the operation record passed from the front unit through the queue.
// ----------------------------------------------------------------------------
package ctr_pkg;

  // list size and derived widths
  localparam int MAX_SLOTS = 8;
  localparam int SLOT_IW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SLOT_CW   = $clog2(MAX_SLOTS + 1);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_IW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // stream widths
  localparam int IN_TDATA_W  = 112;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;

  // commands carried in in_tuser
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  // selection states
  localparam logic [2:0] SEL_SELECTED = 3'd1;
  localparam logic [2:0] SEL_TRACKING = 3'd2;
  localparam logic [2:0] SEL_FAILED   = 3'd3;

  // query actions
  typedef enum logic [1:0] {
    ACT_NONE         = 2'd0,
    ACT_START        = 2'd1,
    ACT_START_FORCED = 2'd2,
    ACT_ABORT        = 2'd3
  } action_t;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_SLOTS    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RETRY_DIST_SQR  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FAILURE_PENALTY = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD_BIAS       = 2'd3;

  // register reset values
  localparam logic [3:0]  ACTIVE_SLOTS_RST    = 4'd8;
  localparam logic [31:0] RETRY_DIST_SQR_RST  = 32'd40000;
  localparam logic [14:0] FAILURE_PENALTY_RST = 15'd10000;
  localparam logic [14:0] HOLD_BIAS_RST       = 15'd100;

  typedef struct packed {
    logic [3:0]  active_slots;
    logic [31:0] retry_dist_sqr;
    logic [14:0] failure_penalty;
    logic [14:0] hold_bias;
  } cfg_t;

  // operations executed by the back unit
  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_INSERT = 2'd2,
    OP_QUERY  = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  id;
    logic [15:0] depth;
    logic        held;
    logic        failed;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/ctr_front.sv
// ----------------------------------------------------------------------------
// ctr_front: input front unit
// Accepts items, classifies the command, computes the squared movement of a
// failed target on one shared multiplier and the effective depth, and pushes
// one operation into the queue.
// ----------------------------------------------------------------------------
module ctr_front
  import ctr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [IN_TUSER_W-1:0] in_tuser,
  input  q_status_t             q_status,
  output logic                  push,
  output op_t                   push_op
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_PUSH
  } state_t;

  localparam int AXIS_Z = 2;

  state_t           state_r;
  logic [1:0]       step_r;
  logic [33:0]      acc_r;
  cmd_t             cmd_r;
  logic [7:0]       id_r;
  logic             live_r;
  logic [2:0]       sel_r;
  logic [2:0][15:0] pos_r;
  logic [2:0][15:0] fail_r;

  // input field unpacking
  logic [7:0]       in_id;
  logic             in_pos_valid;
  logic [2:0][15:0] in_pos;
  logic [2:0]       in_sel;
  logic [2:0][15:0] in_fail;
  logic             in_live;
  logic             in_accept;

  assign in_id        = in_tdata[7:0];
  assign in_pos_valid = in_tdata[8];
  assign in_pos[0]    = in_tdata[24:9];
  assign in_pos[1]    = in_tdata[40:25];
  assign in_pos[2]    = in_tdata[56:41];
  assign in_sel       = in_tdata[59:57];
  assign in_fail[0]   = in_tdata[75:60];
  assign in_fail[1]   = in_tdata[91:76];
  assign in_fail[2]   = in_tdata[107:92];

  // candidate kept only with a position and a depth above zero
  assign in_live   = in_pos_valid && !in_pos[AXIS_Z][15] && (in_pos[AXIS_Z] != 16'd0);
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // one axis of the squared movement per cycle
  logic signed [16:0] diff;
  logic [15:0]        mag;
  logic [31:0]        sq;

  always_comb begin
    diff = $signed({pos_r[step_r][15], pos_r[step_r]})
         - $signed({fail_r[step_r][15], fail_r[step_r]});
    mag  = diff[16] ? 16'(-diff) : diff[15:0];
    sq   = mag * mag;
  end

  // effective depth with failure penalty and hold bias
  logic               held;
  logic               failed;
  logic [16:0]        z_pen;
  logic signed [17:0] z_hold;
  logic [15:0]        depth;

  always_comb begin
    held   = (sel_r == SEL_SELECTED) || (sel_r == SEL_TRACKING);
    failed = (sel_r == SEL_FAILED);
    z_pen  = {1'b0, pos_r[AXIS_Z]};
    if (failed && (acc_r < {2'b00, cfg.retry_dist_sqr})) begin
      z_pen = z_pen + {2'b00, cfg.failure_penalty};
    end
    z_hold = $signed({1'b0, z_pen}) - $signed({3'b000, cfg.hold_bias});
    if (!held) begin
      depth = z_pen[15:0];
    end else if (z_hold[17] || (z_hold == 18'sd0)) begin
      depth = 16'd1;
    end else begin
      depth = z_hold[15:0];
    end
  end

  // operation record
  always_comb begin
    push_op.id     = id_r;
    push_op.depth  = depth;
    push_op.held   = held;
    push_op.failed = failed;
    unique case (cmd_r)
      CMD_CLEAR:  push_op.kind = OP_CLEAR;
      CMD_INSERT: push_op.kind = live_r ? OP_INSERT : OP_NOP;
      CMD_QUERY:  push_op.kind = OP_QUERY;
      CMD_NOP:    push_op.kind = OP_NOP;
    endcase
  end

  assign push = (state_r == ST_PUSH) && !q_status.full;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= 2'd0;
      cmd_r   <= CMD_NOP;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            cmd_r   <= cmd_t'(in_tuser);
            id_r    <= in_id;
            live_r  <= in_live;
            sel_r   <= in_sel;
            pos_r   <= in_pos;
            fail_r  <= in_fail;
            acc_r   <= 34'd0;
            step_r  <= 2'd0;
            if ((cmd_t'(in_tuser) == CMD_INSERT) && in_live && (in_sel == SEL_FAILED)) begin
              state_r <= ST_SQUARE;
            end else begin
              state_r <= ST_PUSH;
            end
          end
        end
        ST_SQUARE: begin
          acc_r  <= acc_r + {2'b00, sq};
          step_r <= step_r + 2'd1;
          if (step_r == 2'(AXIS_Z)) begin
            state_r <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!q_status.full) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/ctr_queue.sv
// ----------------------------------------------------------------------------
// ctr_queue: operation queue between front and back units
// Small first-in first-out buffer of operation records.
// ----------------------------------------------------------------------------
module ctr_queue
  import ctr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  op_t       push_op,
  input  logic      pop,
  output op_t       pop_op,
  output q_status_t status
);

  op_t                 mem_r [QUEUE_DEPTH];
  logic [QUEUE_IW-1:0] wr_ptr_r;
  logic [QUEUE_IW-1:0] rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;

  assign status.full  = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_op       = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_IW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_IW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/ctr_back.sv
// ----------------------------------------------------------------------------
// ctr_back: slot list back unit
// Holds the depth-sorted slot list, executes clear, insert and query
// operations from the queue and registers one result item per operation.
// ----------------------------------------------------------------------------
module ctr_back
  import ctr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  q_status_t              q_status,
  input  op_t                    pop_op,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [MAX_SLOTS-1:0] used_r;
  logic [7:0]           id_r    [MAX_SLOTS];
  logic [15:0]          depth_r [MAX_SLOTS];
  logic [7:0]           id_nxt    [MAX_SLOTS];
  logic [15:0]          depth_nxt [MAX_SLOTS];

  logic                 out_tvalid_r;
  logic                 out_track_r;
  action_t              out_action_r;
  logic                 out_placed_r;

  // effective slot count clamped to 1..MAX_SLOTS
  logic [SLOT_CW-1:0] n_slots;

  always_comb begin
    if (cfg.active_slots == 4'd0) begin
      n_slots = SLOT_CW'(1);
    end else if (32'(cfg.active_slots) > MAX_SLOTS) begin
      n_slots = SLOT_CW'(MAX_SLOTS);
    end else begin
      n_slots = SLOT_CW'(cfg.active_slots);
    end
  end

  assign pop = !q_status.empty && (!out_tvalid_r || out_tready);

  // insert position: first active slot that is empty or not nearer
  logic [MAX_SLOTS-1:0] stop;
  logic [SLOT_IW-1:0]   ins_pos;
  logic                 ins_hit;

  always_comb begin
    ins_pos = '0;
    ins_hit = 1'b0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      stop[i] = (i < int'(n_slots)) && (!used_r[i] || (depth_r[i] >= pop_op.depth));
    end
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (stop[i]) begin
        ins_pos = SLOT_IW'(i);
        ins_hit = 1'b1;
      end
    end
  end

  // shifted list with the candidate written in
  always_comb begin
    for (int j = 0; j < MAX_SLOTS; j++) begin
      id_nxt[j]    = id_r[j];
      depth_nxt[j] = depth_r[j];
    end
    for (int j = 1; j < MAX_SLOTS; j++) begin
      if (used_r[ins_pos] && (j > int'(ins_pos)) && (j < int'(n_slots))) begin
        id_nxt[j]    = id_r[j-1];
        depth_nxt[j] = depth_r[j-1];
      end
    end
    id_nxt[ins_pos]    = pop_op.id;
    depth_nxt[ins_pos] = pop_op.depth;
  end

  logic [MAX_SLOTS-1:0] used_nxt;

  always_comb begin
    used_nxt = used_r;
    for (int j = 1; j < MAX_SLOTS; j++) begin
      if (used_r[ins_pos] && (j > int'(ins_pos)) && (j < int'(n_slots))) begin
        used_nxt[j] = used_r[j-1];
      end
    end
    used_nxt[ins_pos] = 1'b1;
  end

  // membership: scan stops at the first empty slot
  logic found;
  logic alive;

  always_comb begin
    found = 1'b0;
    alive = 1'b1;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (i < int'(n_slots)) begin
        if (alive && used_r[i] && (id_r[i] == pop_op.id)) begin
          found = 1'b1;
        end
        alive = alive && used_r[i];
      end
    end
  end

  // query action
  action_t query_action;

  always_comb begin
    if (found) begin
      if (pop_op.held) begin
        query_action = ACT_NONE;
      end else if (pop_op.failed) begin
        query_action = ACT_START_FORCED;
      end else begin
        query_action = ACT_START;
      end
    end else begin
      query_action = pop_op.held ? ACT_ABORT : ACT_NONE;
    end
  end

  // list update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (pop) begin
      if (pop_op.kind == OP_CLEAR) begin
        used_r <= '0;
      end else if ((pop_op.kind == OP_INSERT) && ins_hit) begin
        used_r <= used_nxt;
        for (int j = 0; j < MAX_SLOTS; j++) begin
          id_r[j]    <= id_nxt[j];
          depth_r[j] <= depth_nxt[j];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (pop) begin
      out_tvalid_r <= 1'b1;
      out_track_r  <= (pop_op.kind == OP_QUERY) && found;
      out_action_r <= (pop_op.kind == OP_QUERY) ? query_action : ACT_NONE;
      out_placed_r <= (pop_op.kind == OP_INSERT) && ins_hit;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0000, out_placed_r, out_action_r, out_track_r};

endmodule

// File: rtl/closest_target_ranker.sv
// ----------------------------------------------------------------------------
// closest_target_ranker: depth-sorted list of the nearest targets
// Keeps up to MAX_SLOTS targets ordered by effective depth and answers
// clear, insert and query commands with one result item each.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : command items; in_tuser carries the command, in_tdata the target.
//   out_*  : one result item for every accepted input item, in order.
//   cfg_*  : register writes, always ready; write only while the block idles.
// Flow:
//   An item passes the front unit in an idle and a push state; an insert of a
//   failed target with a valid position and positive depth also runs a
//   square state, whose squared movement uses one shared multiplier axis by
//   axis. The front takes a new item only when idle again. The result is
//   registered in the back unit. The back unit executes one operation per
//   cycle on the slot registers while its output is free or being taken.
// Reset:
//   rst_n empties the list, loads the register defaults and drops all items
//   in flight.
// Stalls:
//   a result waits in the output register while out_tready is low; the
//   two-entry queue keeps taking front operations until it fills, then the
//   front unit holds and in_tready stays low.
// ----------------------------------------------------------------------------
module closest_target_ranker
  import ctr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input items
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // target_id, pos_valid, pos_x, pos_y, pos_z, sel_state, fail_x, fail_y,
  // fail_z, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  // result items
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // should_track, action, placed, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t      cfg_r;
  q_status_t q_status;
  op_t       push_op;
  op_t       pop_op;
  logic      push;
  logic      pop;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_slots    <= ACTIVE_SLOTS_RST;
      cfg_r.retry_dist_sqr  <= RETRY_DIST_SQR_RST;
      cfg_r.failure_penalty <= FAILURE_PENALTY_RST;
      cfg_r.hold_bias       <= HOLD_BIAS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        REG_ACTIVE_SLOTS:    cfg_r.active_slots    <= cfg_data[3:0];
        REG_RETRY_DIST_SQR:  cfg_r.retry_dist_sqr  <= cfg_data;
        REG_FAILURE_PENALTY: cfg_r.failure_penalty <= cfg_data[14:0];
        REG_HOLD_BIAS:       cfg_r.hold_bias       <= cfg_data[14:0];
      endcase
    end
  end

  // front unit
  ctr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_status  (q_status),
    .push      (push),
    .push_op   (push_op)
  );

  // operation queue
  ctr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (pop_op),
    .status  (q_status)
  );

  // back unit
  ctr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_status   (q_status),
    .pop_op     (pop_op),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  // front never writes into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_status.full)
    else $error("push into full queue");

  // back never reads from an empty queue
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // front works on one item at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("front accepted while busy");
`endif

endmodule
